>>> hw/rtl/uint16_to_decimal_ascii_defines.svh
// Assertion macros shared by the uint16_to_decimal_ascii RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef UINT16_TO_DECIMAL_ASCII_DEFINES_SVH
`define UINT16_TO_DECIMAL_ASCII_DEFINES_SVH

// Implication checked in the same cycle.
`define U2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define U2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/u2da_pkg.sv
// Package for the 16-bit binary to decimal ASCII converter.
// Holds digit constants, the divide-by-ten reciprocal and the queue entry type.
package u2da_pkg;

    localparam int VALUE_W     = 16;
    localparam int DIGITS      = 5;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = 3;
    localparam int CHAR_W      = 6;
    localparam int PROD_W      = 32;
    localparam int QUOT_W      = 13;
    localparam int RECIP_SHIFT = 19;

    localparam logic [VALUE_W-1:0] RECIP_TEN  = 16'hCCCD;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        t_digits          digits;
        logic [CNT_W-1:0] ndig;
    } t_entry;

endpackage

>>> hw/rtl/u2da_front.sv
// Front end: accepts values and splits them into decimal digits, one per cycle; the last waits for queue room.
// Uses u2da_pkg; pushes one digit group per value into u2da_fifo.
module u2da_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_push,
    input  logic                          i_push_ready,
    output u2da_pkg::t_entry              o_entry
);
    import u2da_pkg::*;

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_W-1:0]    r_val;
    t_digits               r_digits;
    t_digits               n_digits;
    logic [PROD_W-1:0]     w_prod;
    logic [QUOT_W-1:0]     w_quot;
    logic [VALUE_W:0]      w_times_ten;
    logic [VALUE_W:0]      w_diff;
    logic [DIGIT_W-1:0]    w_rem;
    logic                  w_final;
    logic                  w_accept;
    logic                  w_advance;

    always_comb begin
        w_prod      = PROD_W'(r_val) * PROD_W'(RECIP_TEN);
        w_quot      = w_prod[RECIP_SHIFT +: QUOT_W];
        w_times_ten = (VALUE_W+1)'({w_quot, 3'b000}) + (VALUE_W+1)'({w_quot, 1'b0});
        w_diff      = (VALUE_W+1)'(r_val) - w_times_ten;
        w_rem       = w_diff[DIGIT_W-1:0];
        w_final     = (w_quot == '0);
        n_digits        = r_digits;
        n_digits[r_cnt] = w_rem;
    end

    assign o_push        = r_busy && w_final;
    assign o_entry       = '{digits: n_digits, ndig: r_cnt + CNT_W'(1)};
    assign w_advance     = r_busy && (!w_final || i_push_ready);
    assign o_ready       = !r_busy || (w_final && i_push_ready);
    assign w_accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_advance) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= i_value;
        end else if (w_advance) begin
            r_val    <= VALUE_W'(w_quot);
            r_digits <= n_digits;
        end
    end

endmodule

>>> hw/rtl/u2da_fifo.sv
// Two-entry queue of digit groups between the front and back ends.
// Uses u2da_pkg for the entry type.
module u2da_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  u2da_pkg::t_entry i_entry,
    output logic             o_valid,
    input  logic             i_pop,
    output u2da_pkg::t_entry o_entry
);
    import u2da_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_wr_en;
    logic       w_rd_en;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_entry      = r_mem[r_rd];
    assign w_wr_en      = i_push && o_push_ready;
    assign w_rd_en      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr_en) begin
                r_wr <= !r_wr;
            end
            if (w_rd_en) begin
                r_rd <= !r_rd;
            end
            if (w_wr_en && !w_rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd_en && !w_wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/u2da_back.sv
// Back end: walks a digit group most significant first into an output register.
// Uses u2da_pkg; pops the queue on the last character of each group.
module u2da_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  u2da_pkg::t_entry              i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2da_pkg::CHAR_W-1:0]   o_char,
    output logic                          o_last
);
    import u2da_pkg::*;

    logic [CNT_W-1:0]   r_pos;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [CNT_W-1:0]   w_top;
    logic [CNT_W-1:0]   w_idx;
    logic               w_is_last;
    logic               w_load;

    assign w_top     = i_entry.ndig - CNT_W'(1);
    assign w_idx     = w_top - r_pos;
    assign w_is_last = (r_pos == w_top);
    assign w_load    = i_valid && (!r_valid || i_ready);
    assign o_pop     = w_load && w_is_last;
    assign o_valid   = r_valid;
    assign o_char    = r_char;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_pos   <= w_is_last ? '0 : r_pos + CNT_W'(1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= ASCII_ZERO + CHAR_W'(i_entry.digits[w_idx]);
            r_last <= w_is_last;
        end
    end

endmodule

>>> hw/rtl/uint16_to_decimal_ascii.sv
// Top level of the 16-bit unsigned binary to decimal ASCII converter.
// Instantiates u2da_front, u2da_fifo and u2da_back; uses u2da_pkg and the defines header.
//
// Usage: each beat on the s_axis side carries one unsigned 16-bit value. The
// m_axis side returns its decimal digits as ASCII characters, most significant
// first, without leading zeros; zero gives the single character '0'. tlast
// marks the final character of each value, so a run holds one to five beats.
// The front end produces one digit per cycle, dividing by ten with a
// reciprocal multiply, but holds the last digit until the queue has room;
// it takes the next value only as that digit is pushed. The back end
// delivers one character per cycle from a two-entry queue while the
// receiver is ready. Values pass from the digit registers through the queue
// to the output register. When the receiver stalls, the output register
// holds its character, the queue fills, and then s_axis_tready drops.
// Reset clears all valid flags and the queue; no character is pending afterward.
`include "uint16_to_decimal_ascii_defines.svh"
module uint16_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        m_axis_tlast
);
    import u2da_pkg::*;

    logic              w_push;
    logic              w_push_ready;
    t_entry            w_push_entry;
    logic              w_head_valid;
    logic              w_pop;
    t_entry            w_head_entry;
    logic [CHAR_W-1:0] w_char;

    u2da_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_entry      (w_push_entry)
    );

    u2da_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_entry      (w_push_entry),
        .o_valid      (w_head_valid),
        .i_pop        (w_pop),
        .o_entry      (w_head_entry)
    );

    u2da_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .o_pop    (w_pop),
        .i_entry  (w_head_entry),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_char   (w_char),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_char};

    `U2DA_ASSERT_NOW(a_char_is_digit, m_axis_tvalid, (w_char >= 6'd48) && (w_char <= 6'd57), "output character is not a decimal digit")
    `U2DA_ASSERT_NOW(a_group_width, w_head_valid, (w_head_entry.ndig != 3'd0) && (w_head_entry.ndig <= 3'd5), "queued digit group has an illegal digit count")
    `U2DA_ASSERT_NEXT(a_run_continues, m_axis_tvalid && !m_axis_tlast, m_axis_tvalid, "a run of characters broke off before its last beat")

endmodule

>>> tb/decimal_ascii_checker.sv
`timescale 1ns / 100ps
// Checker for uint16_to_decimal_ascii: watches both stream channels and predicts the characters.
// Compares every output beat with the oldest predicted character; depends on u2da_pkg.
module decimal_ascii_checker
    import u2da_pkg::VALUE_W, u2da_pkg::CHAR_W, u2da_pkg::ASCII_ZERO;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,    // [15:0] value
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,   // [5:0] digit_char, [7:6] zero
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned RADIX = 10;

    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_char_expect;

    t_char_expect expected_chars[$];
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void queue_decimal_chars(input logic [VALUE_W-1:0] value);
        int unsigned  rest;
        int unsigned  digits_lsb_first[$];
        t_char_expect entry;
        rest = value;
        do begin
            digits_lsb_first.push_back(rest % RADIX);
            rest = rest / RADIX;
        end while (rest != 0);
        for (int k = digits_lsb_first.size() - 1; k >= 0; k--) begin
            entry.digit_char = CHAR_W'(digits_lsb_first[k]) + ASCII_ZERO;
            entry.last       = (k == 0);
            expected_chars.push_back(entry);
        end
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_char_expect oldest;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                queue_decimal_chars(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("Output beat 0x%02h with no character expected", i_out_data);
                    fail_count++;
                end else begin
                    oldest = expected_chars.pop_front();
                    check_field("digit_char", oldest.digit_char, i_out_data[CHAR_W-1:0]);
                    check_field("last", oldest.last, i_out_last);
                    check_field("tdata[7:6]", 0, i_out_data[7:CHAR_W]);
                end
            end
        end
        pending_count = expected_chars.size();
    end

endmodule

>>> tb/tb_uint16_to_decimal_ascii.sv
`timescale 1ns / 100ps
// Testbench top for uint16_to_decimal_ascii: clock, reset, value stimulus and the verdict.
// Instantiates the block and decimal_ascii_checker, which does all prediction and comparison.
module tb_uint16_to_decimal_ascii;

    localparam int RANDOM_VALUES = 420;
    localparam int CYCLE_LIMIT   = 60000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 90;
    localparam int READY_STEADY0 = 1100;
    localparam int READY_STEADY1 = 1500;
    localparam int SEND_STEADY0  = 200;
    localparam int SEND_STEADY1  = 280;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          cycle_count   = 0;

    logic [15:0] corner_values[] = '{
        16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101, 16'd999,
        16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd12345, 16'd54321, 16'd59999,
        16'd60000, 16'd65534, 16'd65535, 16'h8000, 16'h5555, 16'hAAAA, 16'd90, 16'd7
    };

    uint16_to_decimal_ascii u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    decimal_ascii_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_uint16_to_decimal_ascii: FAIL");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so the block backs up into its input, else it is steady or random.
    always @(posedge i_clk) begin
        if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
        end else if (cycle_count >= READY_STEADY0 && cycle_count < READY_STEADY1) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic send_value(input logic [15:0] value, input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < 30);
        end
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    function automatic logic [15:0] random_value();
        int unsigned digits;
        if ($urandom_range(0, 99) < 20) begin
            return 16'($urandom_range(0, 65535));
        end
        digits = $urandom_range(1, 5);
        case (digits)
            1: return 16'($urandom_range(0, 9));
            2: return 16'($urandom_range(10, 99));
            3: return 16'($urandom_range(100, 999));
            4: return 16'($urandom_range(1000, 9999));
            default: return 16'($urandom_range(10000, 65535));
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_values[i]) begin
            send_value(corner_values[i], 1'b1);
        end
        for (int n = 0; n < RANDOM_VALUES; n++) begin
            send_value(random_value(), !(n >= SEND_STEADY0 && n < SEND_STEADY1));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_uint16_to_decimal_ascii: PASS");
        end else begin
            $display("tb_uint16_to_decimal_ascii: FAIL");
        end
        $finish;
    end

endmodule

>>> uint16_to_decimal_ascii.f
+incdir+hw/rtl
hw/rtl/u2da_pkg.sv
hw/rtl/u2da_front.sv
hw/rtl/u2da_fifo.sv
hw/rtl/u2da_back.sv
hw/rtl/uint16_to_decimal_ascii.sv
tb/decimal_ascii_checker.sv
tb/tb_uint16_to_decimal_ascii.sv
